// ===== src/y2rgb_pkg.sv =====
`timescale 1ns / 1ps

package y2rgb_pkg;

   // field widths
   localparam int unsigned PIX_W = 8;
   localparam int unsigned SUM_W = 23;   // signed Q12 channel sum, |sum| < 2^21
   localparam int unsigned COEF_W = 14;  // signed holder for the Q12 coefficients
   localparam int unsigned FRAC_W = 12;
   localparam int unsigned LATENCY = 4;

   // Q12 coefficients
   localparam logic signed [COEF_W-1:0] K_RV = 14'sd5614;
   localparam logic signed [COEF_W-1:0] K_GV = 14'sd2859;
   localparam logic signed [COEF_W-1:0] K_GU = 14'sd1383;
   localparam logic signed [COEF_W-1:0] K_BU = 14'sd7096;

   localparam logic [PIX_W-1:0] CHROMA_MID = 8'd128;
   localparam logic [PIX_W-1:0] CHAN_MAX = 8'd255;
   localparam logic [PIX_W-1:0] ATTEN_MUL = 8'd220;
   localparam logic [PIX_W-1:0] OUT_MAX = 8'd219;

   typedef struct packed {
      logic [PIX_W-1:0] luma_first;
      logic [PIX_W-1:0] chroma_blue;
      logic [PIX_W-1:0] luma_second;
      logic [PIX_W-1:0] chroma_red;
      logic             frame_end;
   } req_word_type;

   typedef struct packed {
      logic [PIX_W-1:0] red_first;
      logic [PIX_W-1:0] green_first;
      logic [PIX_W-1:0] blue_first;
      logic [PIX_W-1:0] red_second;
      logic [PIX_W-1:0] green_second;
      logic [PIX_W-1:0] blue_second;
      logic             frame_last;
   } rsp_word_type;

endpackage

// ===== src/yuyv_to_rgb888_pair.sv =====
`timescale 1ns / 1ps

// Channel   Ports                      Direction  Handshake
// request   start, busy, req_word      in         taken when start && !busy
// response  rsp_strobe, rsp_word       out        single-cycle strobe per word, no backpressure
//
// Four register stages: capture, chroma products, Q12 sums, clamp and attenuate.
// A word accepted at one edge passes the capture, product, sum and result registers before it shows on rsp_word.
// One word per cycle is taken; busy stays low, since nothing can stall the pipe.
// Synchronous reset clears the stage valid bits only; payload registers keep no reset.

module yuyv_to_rgb888_pair (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  y2rgb_pkg::req_word_type  req_word,
   output logic                     rsp_strobe,
   output y2rgb_pkg::rsp_word_type  rsp_word
);

   localparam int unsigned PIX_W = y2rgb_pkg::PIX_W;
   localparam int unsigned SUM_W = y2rgb_pkg::SUM_W;
   localparam int unsigned FRAC_W = y2rgb_pkg::FRAC_W;

   // clamp a Q12 sum to 0..255 after flooring, then scale by 220/256
   function automatic logic [PIX_W-1:0] finish_channel(input logic signed [SUM_W-1:0] sum);
      logic [SUM_W-FRAC_W-1:0] whole;
      logic [PIX_W-1:0]        c;
      logic [2*PIX_W-1:0]      scaled;
      whole = sum[SUM_W-1:FRAC_W];
      if (sum[SUM_W-1]) begin
         c = '0;
      end else if (whole[SUM_W-FRAC_W-1:PIX_W] != '0) begin
         c = y2rgb_pkg::CHAN_MAX;
      end else begin
         c = whole[PIX_W-1:0];
      end
      scaled = c * y2rgb_pkg::ATTEN_MUL;
      return scaled[2*PIX_W-1:PIX_W];
   endfunction

   // stage valid bits
   logic [y2rgb_pkg::LATENCY-1:0] vld_ff, vld_in;

   // stage 1: captured word
   y2rgb_pkg::req_word_type req_ff;

   // stage 2: products and carried lumas
   logic signed [SUM_W-1:0] prod_rv_ff, prod_gv_ff, prod_gu_ff, prod_bu_ff;
   logic signed [SUM_W-1:0] prod_rv_in, prod_gv_in, prod_gu_in, prod_bu_in;
   logic [PIX_W-1:0]        luma0_s2_ff, luma1_s2_ff;
   logic                    fend_s2_ff;
   logic signed [PIX_W-1:0] du, dv;

   // stage 3: channel sums
   logic signed [SUM_W-1:0] r0_ff, g0_ff, b0_ff, r1_ff, g1_ff, b1_ff;
   logic signed [SUM_W-1:0] r0_in, g0_in, b0_in, r1_in, g1_in, b1_in;
   logic signed [SUM_W-1:0] base0, base1;
   logic                    fend_s3_ff;

   // stage 4: result word
   y2rgb_pkg::rsp_word_type rsp_ff, rsp_in;

   assign busy = 1'b0;

   // advance valid bits
   assign vld_in = {vld_ff[y2rgb_pkg::LATENCY-2:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // offset chroma: minus 128 is a flip of the top bit
   assign du = $signed(req_ff.chroma_blue ^ y2rgb_pkg::CHROMA_MID);
   assign dv = $signed(req_ff.chroma_red ^ y2rgb_pkg::CHROMA_MID);

   // form chroma products
   assign prod_rv_in = SUM_W'(y2rgb_pkg::K_RV) * SUM_W'(dv);
   assign prod_gv_in = SUM_W'(y2rgb_pkg::K_GV) * SUM_W'(dv);
   assign prod_gu_in = SUM_W'(y2rgb_pkg::K_GU) * SUM_W'(du);
   assign prod_bu_in = SUM_W'(y2rgb_pkg::K_BU) * SUM_W'(du);

   // sum luma and chroma terms in Q12
   assign base0 = $signed({{(SUM_W-PIX_W-FRAC_W){1'b0}}, luma0_s2_ff, {FRAC_W{1'b0}}});
   assign base1 = $signed({{(SUM_W-PIX_W-FRAC_W){1'b0}}, luma1_s2_ff, {FRAC_W{1'b0}}});
   assign r0_in = base0 + prod_rv_ff;
   assign g0_in = base0 - prod_gv_ff - prod_gu_ff;
   assign b0_in = base0 + prod_bu_ff;
   assign r1_in = base1 + prod_rv_ff;
   assign g1_in = base1 - prod_gv_ff - prod_gu_ff;
   assign b1_in = base1 + prod_bu_ff;

   // clamp and attenuate
   always_comb begin
      rsp_in.red_first = finish_channel(r0_ff);
      rsp_in.green_first = finish_channel(g0_ff);
      rsp_in.blue_first = finish_channel(b0_ff);
      rsp_in.red_second = finish_channel(r1_ff);
      rsp_in.green_second = finish_channel(g1_ff);
      rsp_in.blue_second = finish_channel(b1_ff);
      rsp_in.frame_last = fend_s3_ff;
   end

   // hold payload through the stages
   always_ff @(posedge clock) begin
      req_ff <= req_word;
      prod_rv_ff <= prod_rv_in;
      prod_gv_ff <= prod_gv_in;
      prod_gu_ff <= prod_gu_in;
      prod_bu_ff <= prod_bu_in;
      luma0_s2_ff <= req_ff.luma_first;
      luma1_s2_ff <= req_ff.luma_second;
      fend_s2_ff <= req_ff.frame_end;
      r0_ff <= r0_in;
      g0_ff <= g0_in;
      b0_ff <= b0_in;
      r1_ff <= r1_in;
      g1_ff <= g1_in;
      b1_ff <= b1_in;
      fend_s3_ff <= fend_s2_ff;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = vld_ff[y2rgb_pkg::LATENCY-1];
   assign rsp_word = rsp_ff;

`ifndef SYNTHESIS
   a_word_out: assert property (@(posedge clock) disable iff (reset)
      start |-> ##4 rsp_strobe)
      else $error("accepted word did not come out after four cycles");

   a_no_stray: assert property (@(posedge clock) disable iff (reset)
      !start |-> ##4 !rsp_strobe)
      else $error("strobe without an accepted word");

   a_frame_mark: assert property (@(posedge clock) disable iff (reset)
      start |-> ##4 (rsp_word.frame_last == $past(req_word.frame_end, 4)))
      else $error("frame end mark lost in the pipe");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_word.red_first <= y2rgb_pkg::OUT_MAX
                      && rsp_word.green_second <= y2rgb_pkg::OUT_MAX
                      && rsp_word.blue_second <= y2rgb_pkg::OUT_MAX))
      else $error("channel above attenuated range");

   a_gray: assert property (@(posedge clock) disable iff (reset)
      (start && req_word.chroma_blue == y2rgb_pkg::CHROMA_MID
       && req_word.chroma_red == y2rgb_pkg::CHROMA_MID)
      |-> ##4 (rsp_word.red_first == rsp_word.green_first
               && rsp_word.green_first == rsp_word.blue_first))
      else $error("neutral chroma gave unequal channels");
`endif

endmodule

// ===== tb/yuyv_to_rgb888_pair_tb.sv =====
`timescale 1ns / 1ps

module yuyv_to_rgb888_pair_tb;

   localparam int CLK_PERIOD  = 8;
   localparam int RESET_LEN   = 7;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_WORDS = 1700;
   localparam int MAX_REPORTS = 10;
   localparam int REQ_W = $bits(y2rgb_pkg::req_word_type);

   // Q12 conversion constants
   localparam int Q12_UNIT  = 4096;
   localparam int Q12_SHIFT = 12;
   localparam int COEF_RV   = 5614;
   localparam int COEF_GV   = 2859;
   localparam int COEF_GU   = 1383;
   localparam int COEF_BU   = 7096;
   localparam int MID_CHROMA = 128;
   localparam int CLAMP_TOP = 255;
   localparam int ATTEN_GAIN = 220;
   localparam int ATTEN_SHIFT = 8;

   // Predict converted pairs and hold them until the block returns them
   class pair_scoreboard;
      y2rgb_pkg::rsp_word_type rgb_due[$];
      int                      errors;

      function new();
         errors = 0;
      endfunction

      // Floor, clamp and attenuate one Q12 channel sum
      static function logic [7:0] shade_channel(int q12_sum);
         int level;
         if (q12_sum < 0) begin
            level = 0;
         end else begin
            level = q12_sum >>> Q12_SHIFT;
            if (level > CLAMP_TOP) begin
               level = CLAMP_TOP;
            end
         end
         return 8'((level * ATTEN_GAIN) >> ATTEN_SHIFT);
      endfunction

      static function y2rgb_pkg::rsp_word_type convert_word(y2rgb_pkg::req_word_type w);
         y2rgb_pkg::rsp_word_type r;
         int du;
         int dv;
         int base0;
         int base1;
         du = int'(w.chroma_blue) - MID_CHROMA;
         dv = int'(w.chroma_red) - MID_CHROMA;
         base0 = int'(w.luma_first) * Q12_UNIT;
         base1 = int'(w.luma_second) * Q12_UNIT;
         r.red_first    = shade_channel(base0 + COEF_RV * dv);
         r.green_first  = shade_channel(base0 - COEF_GV * dv - COEF_GU * du);
         r.blue_first   = shade_channel(base0 + COEF_BU * du);
         r.red_second   = shade_channel(base1 + COEF_RV * dv);
         r.green_second = shade_channel(base1 - COEF_GV * dv - COEF_GU * du);
         r.blue_second  = shade_channel(base1 + COEF_BU * du);
         r.frame_last   = w.frame_end;
         return r;
      endfunction

      function void note_word(y2rgb_pkg::req_word_type w);
         rgb_due.push_back(convert_word(w));
      endfunction

      function void check_word(y2rgb_pkg::rsp_word_type got);
         y2rgb_pkg::rsp_word_type want;
         logic                    bad;
         if (rgb_due.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("unexpected rgb word %h at %0t", got, $realtime);
            end
            return;
         end
         want = rgb_due.pop_front();
         bad = (got.red_first !== want.red_first) ||
               (got.green_first !== want.green_first) ||
               (got.blue_first !== want.blue_first) ||
               (got.red_second !== want.red_second) ||
               (got.green_second !== want.green_second) ||
               (got.blue_second !== want.blue_second) ||
               (got.frame_last !== want.frame_last);
         if (bad) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("rgb mismatch at %0t: exp %0d/%0d/%0d %0d/%0d/%0d fe=%0b",
                        $realtime, want.red_first, want.green_first, want.blue_first,
                        want.red_second, want.green_second, want.blue_second,
                        want.frame_last);
               $display("                     got %0d/%0d/%0d %0d/%0d/%0d fe=%0b",
                        got.red_first, got.green_first, got.blue_first,
                        got.red_second, got.green_second, got.blue_second,
                        got.frame_last);
            end
         end
      endfunction

      function int pending();
         return rgb_due.size();
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   y2rgb_pkg::req_word_type req_word;
   logic                    rsp_strobe;
   y2rgb_pkg::rsp_word_type rsp_word;

   pair_scoreboard rgb_board = new();
   int             idle_cycles;

   yuyv_to_rgb888_pair u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Note accepted words, check returned words, and watch for a stall
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (start && !busy) begin
            rgb_board.note_word(req_word);
         end
         if (rsp_strobe) begin
            rgb_board.check_word(rsp_word);
         end
         if ((start && !busy) || rsp_strobe) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   function automatic y2rgb_pkg::req_word_type make_word(int y0, int u, int y1, int v, bit fe);
      y2rgb_pkg::req_word_type w;
      w.luma_first  = 8'(y0);
      w.chroma_blue = 8'(u);
      w.luma_second = 8'(y1);
      w.chroma_red  = 8'(v);
      w.frame_end   = fe;
      return w;
   endfunction

   // No gap in a burst; else mostly none, often a short one, now and then a long one
   function automatic int pick_gap(bit burst);
      int roll;
      if (burst) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end else if (roll < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Random words biased toward neutral chroma, extreme chroma, extreme luma and full range
   function automatic y2rgb_pkg::req_word_type random_word();
      y2rgb_pkg::req_word_type w;
      int mode;
      w = REQ_W'({$urandom, $urandom});
      w.frame_end = ($urandom_range(0, 15) == 0);
      mode = $urandom_range(0, 99);
      if (mode < 20) begin
         w.chroma_blue = 8'($urandom_range(120, 136));
         w.chroma_red  = 8'($urandom_range(120, 136));
      end else if (mode < 35) begin
         w.chroma_blue = $urandom_range(0, 1) ? 8'($urandom_range(0, 15))
                                              : 8'($urandom_range(240, 255));
         w.chroma_red  = $urandom_range(0, 1) ? 8'($urandom_range(0, 15))
                                              : 8'($urandom_range(240, 255));
      end else if (mode < 50) begin
         w.luma_first  = $urandom_range(0, 1) ? 8'($urandom_range(0, 8))
                                              : 8'($urandom_range(247, 255));
         w.luma_second = $urandom_range(0, 1) ? 8'($urandom_range(0, 8))
                                              : 8'($urandom_range(247, 255));
      end
      return w;
   endfunction

   // Offer one word, hold it until taken, then idle for the given gap
   task automatic send_word(input y2rgb_pkg::req_word_type w, input int gap);
      start <= 1'b1;
      req_word <= w;
      do begin
         @(posedge clock);
      end while (busy !== 1'b0);
      if (gap > 0) begin
         start <= 1'b0;
         req_word <= REQ_W'({$urandom, $urandom});
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic run_directed();
      // neutral chroma at luma extremes, then all-zero and all-ones words
      send_word(make_word(0, 128, 255, 128, 1'b0), pick_gap(1'b0));
      send_word(make_word(255, 128, 0, 128, 1'b1), pick_gap(1'b0));
      send_word(make_word(0, 0, 0, 0, 1'b0), pick_gap(1'b0));
      send_word(make_word(255, 255, 255, 255, 1'b1), pick_gap(1'b0));
      // negative sums: low luma with strong chroma in each direction
      send_word(make_word(0, 0, 16, 255, 1'b0), pick_gap(1'b0));
      send_word(make_word(0, 255, 16, 0, 1'b0), pick_gap(1'b0));
      send_word(make_word(10, 255, 40, 255, 1'b0), pick_gap(1'b0));
      // sums above range: high luma with strong chroma
      send_word(make_word(255, 255, 235, 0, 1'b0), pick_gap(1'b0));
      send_word(make_word(255, 0, 235, 255, 1'b0), pick_gap(1'b0));
      send_word(make_word(200, 0, 255, 0, 1'b1), pick_gap(1'b0));
      // near neutral: one step off mid, then exactly mid
      send_word(make_word(128, 127, 128, 129, 1'b0), pick_gap(1'b0));
      send_word(make_word(1, 129, 254, 127, 1'b0), pick_gap(1'b0));
      send_word(make_word(16, 128, 235, 128, 1'b0), pick_gap(1'b0));
      // alternating bit patterns, then values either side of mid
      send_word(make_word(8'h55, 8'hAA, 8'hAA, 8'h55, 1'b1), pick_gap(1'b0));
      send_word(make_word(8'hAA, 8'h55, 8'h55, 8'hAA, 1'b0), 0);
      send_word(make_word(8'h80, 8'h7F, 8'h7F, 8'h80, 1'b1), pick_gap(1'b0));
   endtask

   initial begin
      int  sent;
      int  drain;
      bit  burst;
      start    <= 1'b0;
      req_word <= '0;
      reset    <= 1'b1;
      repeat (RESET_LEN) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      // Random words, in stretches of 64 that are bursts without idling or have random gaps
      sent = 0;
      burst = 1'b0;
      while (sent < RANDOM_WORDS) begin
         if (sent % 64 == 0) begin
            burst = ($urandom_range(0, 3) == 0);
         end
         send_word(random_word(), pick_gap(burst));
         sent++;
      end
      start <= 1'b0;
      req_word <= '0;

      // Drain the pipe, then keep watching for stray words
      while (rgb_board.pending() != 0) begin
         @(posedge clock);
      end
      drain = 2 * y2rgb_pkg::LATENCY + 4;
      repeat (drain) @(posedge clock);

      if (rgb_board.errors == 0 && rgb_board.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
